// ===== rtl/packet_dedup_filter_top_defines.svh =====
// ----------------------------------------------------------------------------
// packet_dedup_filter_top_defines
// assertion macros for the duplicate packet filter, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef PACKET_DEDUP_FILTER_TOP_DEFINES_SVH
`define PACKET_DEDUP_FILTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent holds in the same cycle as the consequent
`define PDF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pdf assertion failed");
// consequent holds in the cycle after the antecedent
`define PDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pdf assertion failed");
`else
`define PDF_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PDF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/pdf_pkg.sv =====
// ----------------------------------------------------------------------------
// pdf_pkg
// shared types and constants of the duplicate packet filter
// ----------------------------------------------------------------------------
package pdf_pkg;

    localparam int SUM_W  = 32;
    localparam int HALF_W = 16;
    localparam int TIME_W = 40;
    localparam int CNT_W  = 9;
    localparam int TMO_W  = 32;

    localparam logic [HALF_W-1:0] ADLER_MOD      = 16'd65521;
    localparam logic [HALF_W-1:0] ADLER_LOW_INIT = 16'd1;
    localparam logic [HALF_W-1:0] ADLER_HI_INIT  = 16'd0;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 32'd60000;

    // input operation codes
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_PURGE = 1'b1;

    // result kinds
    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_PURGE   = 1'b1;

    // checksum unit control
    typedef struct packed {
        logic upd;
        logic last;
    } t_adler_ctl;

endpackage

// ===== rtl/pdf_ram.sv =====
// ----------------------------------------------------------------------------
// pdf_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module pdf_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 256
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pdf_adler.sv =====
// ----------------------------------------------------------------------------
// pdf_adler
// running adler-32 sums over the bytes of one packet
// ----------------------------------------------------------------------------
module pdf_adler
    import pdf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_adler_ctl       i_ctl,
    input  logic [7:0]       i_byte,
    output logic [SUM_W-1:0] o_sum
);

    logic [HALF_W-1:0] r_s1;
    logic [HALF_W-1:0] r_s2;
    logic [HALF_W:0]   t1;
    logic [HALF_W:0]   t2;
    logic [HALF_W-1:0] n_s1;
    logic [HALF_W-1:0] n_s2;

    always_comb begin
        t1 = {1'b0, r_s1} + {9'd0, i_byte};
        n_s1 = (t1 >= {1'b0, ADLER_MOD}) ? HALF_W'(t1 - {1'b0, ADLER_MOD})
                                         : t1[HALF_W-1:0];
        t2 = {1'b0, r_s2} + {1'b0, n_s1};
        n_s2 = (t2 >= {1'b0, ADLER_MOD}) ? HALF_W'(t2 - {1'b0, ADLER_MOD})
                                         : t2[HALF_W-1:0];
    end

    // sum including the byte on the input
    assign o_sum = {n_s2, n_s1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= ADLER_LOW_INIT;
            r_s2 <= ADLER_HI_INIT;
        end else if (i_ctl.upd) begin
            if (i_ctl.last) begin
                r_s1 <= ADLER_LOW_INIT;
                r_s2 <= ADLER_HI_INIT;
            end else begin
                r_s1 <= n_s1;
                r_s2 <= n_s2;
            end
        end
    end

endmodule

// ===== rtl/packet_dedup_filter_top.sv =====
// ----------------------------------------------------------------------------
// packet_dedup_filter_top
// duplicate packet filter keyed on the adler-32 sum of each packet
// ----------------------------------------------------------------------------
// Command channel: an item is taken when start is high and busy is low.
// A packet byte (op 0) updates the running sum and busy stays low, so
// bytes may follow back to back. A byte marked last, or a purge (op 1),
// walks the sum/stamp ram one entry per cycle while busy is high; the
// result appears with o_result_strobe in the same cycle that busy falls,
// where a new item may already be started.
// Each result strobe lasts exactly one cycle; the receiver cannot
// stall it. The timeout register is written over the cfg channel, which is
// always ready; write it only while the block is idle.
// Reset clears the running sum, all valid bits, the entry count and the
// duplicate counter, and loads a 60000 ms timeout. The ram itself is not
// cleared: an entry's data is used only when its valid flop is set.
// ----------------------------------------------------------------------------
`include "packet_dedup_filter_top_defines.svh"

module packet_dedup_filter_top
    import pdf_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_op,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    input  logic [TIME_W-1:0] i_now_ms,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [TMO_W-1:0]  i_cfg_data,
    output logic              o_result_strobe,
    output logic              o_result_kind,
    output logic [SUM_W-1:0]  o_packet_sum,
    output logic              o_is_new,
    output logic              o_table_full,
    output logic [CNT_W-1:0]  o_entries_in_use,
    output logic [31:0]       o_duplicate_count
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int DW = SUM_W + TIME_W;
    localparam logic [AW:0]   WALK_END = (AW + 1)'(TABLE_ENTRIES);
    localparam logic [CW-1:0] CNT_FULL = CW'(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_PURGE
    } t_state;

    t_state            r_state;
    logic [TMO_W-1:0]  r_timeout;
    logic [SUM_W-1:0]  r_sum;
    logic [TIME_W-1:0] r_now;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [CW-1:0]     r_count;
    logic [31:0]       r_dup;
    logic [AW:0]       r_rd_idx;
    logic [AW-1:0]     r_chk_idx;
    logic              r_chk_vld;
    logic              r_found;
    logic              r_have_free;
    logic [AW-1:0]     r_free_idx;

    t_adler_ctl        adler_ctl;
    logic [SUM_W-1:0]  adler_sum;
    logic              take;
    logic [DW-1:0]     ram_rdata;
    logic              ram_we;
    logic [SUM_W-1:0]  ent_sum;
    logic [TIME_W-1:0] ent_stamp;
    logic [TIME_W-1:0] age;
    logic              aged;
    logic              chk_valid;
    logic              walk_done;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign take        = start && !busy;

    assign adler_ctl.upd  = take && (i_op == OP_BYTE);
    assign adler_ctl.last = i_last_byte;

    pdf_adler u_adler (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (adler_ctl),
        .i_byte  (i_data_byte),
        .o_sum   (adler_sum)
    );

    // the only write comes in the closing cycle of a lookup walk, when no
    // read is outstanding, so reads and writes of one entry never overlap
    assign ram_we = (r_state == S_LOOK) && walk_done && !r_found && r_have_free;

    pdf_ram #(
        .WIDTH (DW),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_free_idx),
        .i_wdata ({r_sum, r_now}),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        ent_sum   = ram_rdata[DW-1:TIME_W];
        ent_stamp = ram_rdata[TIME_W-1:0];
        age       = r_now - ent_stamp;
        aged      = (age >= {8'd0, r_timeout});
        chk_valid = r_valid[r_chk_idx];
        walk_done = (r_rd_idx == WALK_END) && !r_chk_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_timeout       <= TIMEOUT_RESET;
            r_valid         <= '0;
            r_count         <= '0;
            r_dup           <= '0;
            r_rd_idx        <= '0;
            r_chk_vld       <= 1'b0;
            r_found         <= 1'b0;
            r_have_free     <= 1'b0;
            o_result_strobe <= 1'b0;
        end else begin
            o_result_strobe <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    r_rd_idx    <= '0;
                    r_chk_vld   <= 1'b0;
                    r_found     <= 1'b0;
                    r_have_free <= 1'b0;
                    if (take) begin
                        r_now <= i_now_ms;
                        if (i_op == OP_PURGE) begin
                            r_state <= S_PURGE;
                        end else if (i_last_byte) begin
                            r_sum   <= adler_sum;
                            r_state <= S_LOOK;
                        end
                    end
                end
                S_LOOK, S_PURGE: begin
                    // one read issued per cycle, checked the cycle after
                    if (r_rd_idx != WALK_END) begin
                        r_chk_vld <= 1'b1;
                        r_chk_idx <= r_rd_idx[AW-1:0];
                        r_rd_idx  <= r_rd_idx + (AW + 1)'(1);
                    end else begin
                        r_chk_vld <= 1'b0;
                    end
                    if (r_state == S_LOOK) begin
                        if (r_chk_vld) begin
                            if (chk_valid) begin
                                if (ent_sum == r_sum) begin
                                    r_found <= 1'b1;
                                end
                            end else if (!r_have_free) begin
                                r_have_free <= 1'b1;
                                r_free_idx  <= r_chk_idx;
                            end
                        end
                        if (walk_done) begin
                            o_result_strobe <= 1'b1;
                            o_result_kind   <= KIND_VERDICT;
                            o_packet_sum    <= r_sum;
                            o_is_new        <= !r_found;
                            o_table_full    <= !r_found && !r_have_free;
                            if (r_found) begin
                                r_dup             <= r_dup + 32'd1;
                                o_duplicate_count <= r_dup + 32'd1;
                                o_entries_in_use  <= CNT_W'(r_count);
                            end else if (r_have_free) begin
                                r_valid[r_free_idx] <= 1'b1;
                                r_count             <= r_count + CW'(1);
                                o_entries_in_use    <= CNT_W'(r_count + CW'(1));
                                o_duplicate_count   <= r_dup;
                            end else begin
                                o_entries_in_use  <= CNT_W'(r_count);
                                o_duplicate_count <= r_dup;
                            end
                            r_state <= S_IDLE;
                        end
                    end else begin
                        if (r_chk_vld && chk_valid && aged) begin
                            r_valid[r_chk_idx] <= 1'b0;
                            r_count            <= r_count - CW'(1);
                        end
                        if (walk_done) begin
                            o_result_strobe   <= 1'b1;
                            o_result_kind     <= KIND_PURGE;
                            o_packet_sum      <= '0;
                            o_is_new          <= 1'b0;
                            o_table_full      <= 1'b0;
                            o_entries_in_use  <= CNT_W'(r_count);
                            o_duplicate_count <= r_dup;
                            r_state           <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `PDF_ASSERT_SAME(a_strobe_when_idle, i_clk, i_rst_n, o_result_strobe, !busy)
    `PDF_ASSERT_SAME(a_count_bounded, i_clk, i_rst_n, 1'b1, r_count <= CNT_FULL)
    `PDF_ASSERT_NEXT(a_walk_starts, i_clk, i_rst_n, take && (i_op == OP_PURGE || i_last_byte), busy)
    `PDF_ASSERT_SAME(a_full_means_full, i_clk, i_rst_n, o_result_strobe && o_table_full, o_is_new && r_count == CNT_FULL)

endmodule

// ===== tb/packet_dedup_filter_checker.sv =====
// ----------------------------------------------------------------------------
// packet_dedup_filter_checker
// watches the command, config and result channels of the duplicate packet
// filter, keeps its own adler-32 sums and entry table, and compares every
// result strobe field by field against the oldest predicted verdict
// ----------------------------------------------------------------------------
module packet_dedup_filter_checker
    import pdf_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              i_op,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    input  logic [TIME_W-1:0] i_now_ms,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [TMO_W-1:0]  i_cfg_data,
    input  logic              i_result_strobe,
    input  logic              i_result_kind,
    input  logic [SUM_W-1:0]  i_packet_sum,
    input  logic              i_is_new,
    input  logic              i_table_full,
    input  logic [CNT_W-1:0]  i_entries_in_use,
    input  logic [31:0]       i_duplicate_count,
    output int                o_mismatches,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             kind;
        logic [SUM_W-1:0] sum;
        logic             is_new;
        logic             full;
        logic [CNT_W-1:0] in_use;
        logic [31:0]      dups;
    } t_verdict;

    t_verdict          pending_verdicts[$];
    logic [HALF_W-1:0] run_low;
    logic [HALF_W-1:0] run_high;
    logic              slot_valid [TABLE_ENTRIES];
    logic [SUM_W-1:0]  slot_sum   [TABLE_ENTRIES];
    logic [TIME_W-1:0] slot_stamp [TABLE_ENTRIES];
    logic [CNT_W-1:0]  live_slots;
    logic [31:0]       dup_total;
    logic [TMO_W-1:0]  purge_age;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t ns] mismatch: %s", $time, msg);
        o_mismatches++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    function automatic void fold_byte(input logic [7:0] b);
        logic [HALF_W:0] acc;
        acc = {1'b0, run_low} + {9'b0, b};
        if (acc >= {1'b0, ADLER_MOD}) acc = acc - {1'b0, ADLER_MOD};
        run_low = acc[HALF_W-1:0];
        acc = {1'b0, run_high} + {1'b0, run_low};
        if (acc >= {1'b0, ADLER_MOD}) acc = acc - {1'b0, ADLER_MOD};
        run_high = acc[HALF_W-1:0];
    endfunction

    function automatic t_verdict purge_aged(input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] age;
        t_verdict          v;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            // age wraps at the width of the time stamp
            age = now - slot_stamp[i];
            if (slot_valid[i] && age >= {{(TIME_W-TMO_W){1'b0}}, purge_age}) begin
                slot_valid[i] = 1'b0;
                live_slots    = live_slots - CNT_W'(1);
            end
        end
        v.kind   = KIND_PURGE;
        v.sum    = '0;
        v.is_new = 1'b0;
        v.full   = 1'b0;
        v.in_use = live_slots;
        v.dups   = dup_total;
        return v;
    endfunction

    function automatic t_verdict judge_packet(input logic [TIME_W-1:0] now);
        logic [SUM_W-1:0] sum;
        logic             found;
        logic             have_free;
        int               free_idx;
        t_verdict         v;
        sum       = {run_high, run_low};
        run_low   = ADLER_LOW_INIT;
        run_high  = ADLER_HI_INIT;
        found     = 1'b0;
        have_free = 1'b0;
        free_idx  = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot_valid[i]) begin
                if (slot_sum[i] == sum) found = 1'b1;
            end else if (!have_free) begin
                have_free = 1'b1;
                free_idx  = i;
            end
        end
        v.kind   = KIND_VERDICT;
        v.sum    = sum;
        v.is_new = !found;
        v.full   = 1'b0;
        if (found) begin
            dup_total = dup_total + 32'd1;
        end else if (have_free) begin
            // lowest free slot takes the new sum
            slot_valid[free_idx] = 1'b1;
            slot_sum[free_idx]   = sum;
            slot_stamp[free_idx] = now;
            live_slots           = live_slots + CNT_W'(1);
        end else begin
            v.full = 1'b1;
        end
        v.in_use = live_slots;
        v.dups   = dup_total;
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            pending_verdicts.delete();
            run_low  = ADLER_LOW_INIT;
            run_high = ADLER_HI_INIT;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                slot_valid[i] = 1'b0;
                slot_sum[i]   = '0;
                slot_stamp[i] = '0;
            end
            live_slots = '0;
            dup_total  = '0;
            purge_age  = TIMEOUT_RESET;
            o_pending <= 0;
        end else begin
            // the strobe belongs to an older transaction, so retire it first
            if (i_result_strobe) begin
                if (pending_verdicts.size() == 0) begin
                    report_mismatch($sformatf("result with sum %0h and none expected",
                                              i_packet_sum));
                end else begin
                    want = pending_verdicts.pop_front();
                    check_field("result_kind", 64'(i_result_kind), 64'(want.kind));
                    check_field("packet_sum", 64'(i_packet_sum), 64'(want.sum));
                    check_field("is_new", 64'(i_is_new), 64'(want.is_new));
                    check_field("table_full", 64'(i_table_full), 64'(want.full));
                    check_field("entries_in_use", 64'(i_entries_in_use), 64'(want.in_use));
                    check_field("duplicate_count", 64'(i_duplicate_count), 64'(want.dups));
                end
            end
            if (i_cfg_valid && i_cfg_ready) purge_age = i_cfg_data;
            if (start && !busy) begin
                if (i_op == OP_PURGE) begin
                    pending_verdicts.push_back(purge_aged(i_now_ms));
                end else begin
                    fold_byte(i_data_byte);
                    if (i_last_byte) pending_verdicts.push_back(judge_packet(i_now_ms));
                end
            end
            o_pending <= pending_verdicts.size();
        end
    end

endmodule

// ===== tb/packet_dedup_filter_top_tb.sv =====
// ----------------------------------------------------------------------------
// packet_dedup_filter_top_tb
// drives packets and purges into the duplicate packet filter: a directed
// pass over checksum, lookup, aging and timeout corners, a table fill to
// capacity with a long packet, then random phases under several timeouts,
// most with random idle gaps; the checker does all prediction and comparison
// ----------------------------------------------------------------------------
module packet_dedup_filter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pdf_pkg::*;

    localparam int                TABLE_ENTRIES = 256;
    localparam logic [TIME_W-1:0] TIME_MAX      = '1;

    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              start            = 1'b0;
    logic              busy;
    logic              i_op             = OP_BYTE;
    logic [7:0]        i_data_byte      = '0;
    logic              i_last_byte      = 1'b0;
    logic [TIME_W-1:0] i_now_ms         = '0;
    logic              i_cfg_valid      = 1'b0;
    logic              o_cfg_ready;
    logic [TMO_W-1:0]  i_cfg_data       = '0;
    logic              o_result_strobe;
    logic              o_result_kind;
    logic [SUM_W-1:0]  o_packet_sum;
    logic              o_is_new;
    logic              o_table_full;
    logic [CNT_W-1:0]  o_entries_in_use;
    logic [31:0]       o_duplicate_count;

    int                mismatches;
    int                pending;
    int                items_sent    = 0;
    int                verdicts_due  = 0;
    logic              steady_phase  = 1'b0;
    logic [7:0]        pkt_buf [320];
    logic [7:0]        pool_data [6][4];
    int                pool_len [6];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    packet_dedup_filter_top #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .i_now_ms         (i_now_ms),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_result_strobe  (o_result_strobe),
        .o_result_kind    (o_result_kind),
        .o_packet_sum     (o_packet_sum),
        .o_is_new         (o_is_new),
        .o_table_full     (o_table_full),
        .o_entries_in_use (o_entries_in_use),
        .o_duplicate_count(o_duplicate_count)
    );

    packet_dedup_filter_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .i_now_ms         (i_now_ms),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_result_strobe  (o_result_strobe),
        .i_result_kind    (o_result_kind),
        .i_packet_sum     (o_packet_sum),
        .i_is_new         (o_is_new),
        .i_table_full     (o_table_full),
        .i_entries_in_use (o_entries_in_use),
        .i_duplicate_count(o_duplicate_count),
        .o_mismatches     (mismatches),
        .o_pending        (pending)
    );

    function automatic int pick_gap();
        int r;
        if (steady_phase) return 0;
        r = int'($urandom_range(0, 99));
        if (r < 50) return 0;
        if (r < 85) return int'($urandom_range(1, 3));
        if (r < 96) return int'($urandom_range(4, 20));
        return int'($urandom_range(100, 300));
    endfunction

    // start stays high until the transaction is taken, then maybe an idle gap
    task automatic issue_item(input logic op, input logic [7:0] data, input logic last,
                              input logic [TIME_W-1:0] now);
        int gap;
        start       <= 1'b1;
        i_op        <= op;
        i_data_byte <= data;
        i_last_byte <= last;
        i_now_ms    <= now;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_purge(input logic [TIME_W-1:0] now, input logic [7:0] data,
                              input logic last);
        issue_item(OP_PURGE, data, last, now);
        verdicts_due++;
    endtask

    task automatic send_packet(input int len, input logic [TIME_W-1:0] now,
                               input int purge_pct);
        for (int i = 0; i < len; i++) begin
            if (i > 0 && int'($urandom_range(0, 99)) < purge_pct) begin
                send_purge(now, 8'($urandom), 1'($urandom));
            end
            issue_item(OP_BYTE, pkt_buf[i], (i == len - 1), now);
        end
        verdicts_due++;
    endtask

    // table walks leave no trace once the last verdict is out, but a plain
    // byte may still be in flight, so allow a full walk before touching cfg
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TABLE_ENTRIES + 4) @(posedge i_clk);
    endtask

    task automatic set_timeout(input logic [TMO_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [TIME_W-1:0] now;
        logic [TMO_W-1:0]  phase_timeout;
        int                phase_items;
        int                phase_verdicts;
        int                len;
        int                pick;
        int                slot_pick;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // checksum corners and a duplicate, reset timeout
        pkt_buf[0] = 8'h00;
        send_packet(1, '0, 0);
        pkt_buf[0] = 8'hFF;
        send_packet(1, TIME_W'(1), 0);
        pkt_buf[0] = 8'h00;
        send_packet(1, TIME_W'(2), 0);
        pkt_buf[0] = 8'hFF;
        pkt_buf[1] = 8'hFF;
        pkt_buf[2] = 8'hFF;
        send_packet(3, TIME_MAX, 0);

        // purge between bytes keeps the running sum; its data and last are ignored
        issue_item(OP_BYTE, 8'h12, 1'b0, TIME_MAX);
        send_purge(TIME_MAX, 8'hFF, 1'b1);
        issue_item(OP_BYTE, 8'h34, 1'b1, TIME_MAX);
        verdicts_due++;
        pkt_buf[0] = 8'h12;
        pkt_buf[1] = 8'h34;
        send_packet(2, TIME_W'(5), 0);

        // age just below and at the timeout, plain and across the time wrap
        wait_idle();
        set_timeout(32'd10);
        pkt_buf[0] = 8'hAA;
        send_packet(1, TIME_W'(100), 0);
        send_purge(TIME_W'(109), 8'h00, 1'b0);
        send_purge(TIME_W'(110), 8'h00, 1'b0);
        pkt_buf[0] = 8'h55;
        send_packet(1, TIME_MAX - TIME_W'(2), 0);
        send_purge(TIME_W'(6), 8'h00, 1'b0);
        send_purge(TIME_W'(7), 8'h00, 1'b0);

        // zero timeout drops even a fresh entry
        wait_idle();
        set_timeout('0);
        pkt_buf[0] = 8'h01;
        pkt_buf[1] = 8'h02;
        send_packet(2, TIME_W'(1000), 0);
        send_purge(TIME_W'(1000), 8'h00, 1'b0);

        wait_idle();
        set_timeout('1);
        pkt_buf[0] = 8'h00;
        send_packet(1, '0, 0);
        send_purge(TIME_MAX, 8'h00, 1'b0);
        send_purge('0, 8'h00, 1'b0);

        // empty the table, then fill every slot with distinct one-byte sums
        wait_idle();
        set_timeout('0);
        send_purge('0, 8'h00, 1'b0);
        wait_idle();
        set_timeout(32'd1000);
        for (int k = 0; k < 256; k++) begin
            pkt_buf[0] = 8'(k);
            send_packet(1, TIME_W'(k * 10), 0);
        end
        pkt_buf[0] = 8'h01;
        pkt_buf[1] = 8'h02;
        send_packet(2, TIME_W'(2560), 0);
        pkt_buf[0] = 8'h07;
        send_packet(1, TIME_W'(2560), 0);
        // long packet so both running sums wrap the modulus
        for (int k = 0; k < 280; k++) pkt_buf[k] = 8'($urandom_range(240, 255));
        send_packet(280, TIME_W'(2560), 0);
        send_purge(TIME_W'(2560), 8'h00, 1'b0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       phase_timeout = 32'($urandom_range(200, 3000));
                1:       phase_timeout = '1;
                2:       phase_timeout = 32'd1;
                default: phase_timeout = 32'($urandom);
            endcase
            wait_idle();
            set_timeout(phase_timeout);
            steady_phase = (phase == 1);
            if (phase == 3) now = TIME_MAX - TIME_W'($urandom_range(0, 2000));
            else            now = TIME_W'({$urandom, $urandom});
            for (int j = 0; j < 6; j++) begin
                pool_len[j] = int'($urandom_range(1, 4));
                for (int k = 0; k < 4; k++) pool_data[j][k] = 8'($urandom);
            end
            phase_items    = items_sent;
            phase_verdicts = verdicts_due;
            // a small pool of payloads keeps duplicates frequent
            while (items_sent - phase_items < 100 || verdicts_due - phase_verdicts < 15) begin
                if ($urandom_range(0, 9) == 0) now = now + TIME_W'($urandom_range(1000, 100000));
                else                           now = now + TIME_W'($urandom_range(0, 60));
                pick = int'($urandom_range(0, 99));
                if (pick < 12) begin
                    send_purge(now, 8'($urandom), 1'($urandom));
                end else if (pick < 70) begin
                    slot_pick = int'($urandom_range(0, 5));
                    for (int k = 0; k < 4; k++) pkt_buf[k] = pool_data[slot_pick][k];
                    send_packet(pool_len[slot_pick], now, 4);
                end else begin
                    len = int'($urandom_range(1, 6));
                    for (int k = 0; k < len; k++) pkt_buf[k] = 8'($urandom);
                    send_packet(len, now, 4);
                end
            end
        end

        steady_phase = 1'b0;
        wait_idle();
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pdf_pkg.sv
rtl/pdf_ram.sv
rtl/pdf_adler.sv
rtl/packet_dedup_filter_top.sv
tb/packet_dedup_filter_checker.sv
tb/packet_dedup_filter_top_tb.sv
